[rtl/vghp_pkg.sv]
package vghp_pkg;

    localparam int MAX_FRAME_DEF = 1024;

    localparam int SAMPLE_W      = 16;
    localparam int FRAME_LEN_W   = 11;
    localparam int THRESHOLD_W   = 16;
    localparam int HANGOVER_W    = 12;

    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_LEN  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HANGOVER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TX_ENABLE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MUTE       = 3'd4;

    localparam logic [FRAME_LEN_W-1:0] FRAME_LEN_RST = 11'd160;
    localparam logic [HANGOVER_W-1:0]  HANGOVER_RST  = 12'd50;

    localparam int GATE_W = 2;
    localparam logic [GATE_W-1:0] GATE_WAITING = 2'd0;
    localparam logic [GATE_W-1:0] GATE_START   = 2'd1;
    localparam logic [GATE_W-1:0] GATE_NORMAL  = 2'd2;

    typedef struct packed {
        logic keep;
        logic last;
        logic hit;
    } t_rd_tag;

endpackage

[rtl/vghp_ram.sv]
module vghp_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/voice_gate_hangover_preroll.sv]
// Voice gate with hangover and one frame of pre-roll. Samples are grouped into frames of
// frame_len samples (0 counts as 1, values above MAX_FRAME saturate); a frame is speech when
// any sample, signed, is at or above the unsigned speech_threshold. At each frame end, if
// transmit is enabled and not muted, a waiting/start/normal gate with a hangover counter
// decides keep and on onset the frame before is kept too; else the frame is not kept. Each
// item yields one result: the sample written two frames earlier, its frame's keep flag and
// a last-of-frame flag. One item is taken every cycle unless the output stalls; results
// pass the delay RAM (2*MAX_FRAME x 16) read register, then the output register. No clearing
// pass follows reset: a write pointer wrap flag marks which RAM entries hold data, and the
// rest read as zero. The user writes configuration while the block is idle; not enforced.
module voice_gate_hangover_preroll
    import vghp_pkg::*;
#(
    parameter int MAX_FRAME = MAX_FRAME_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [SAMPLE_W-1:0]   i_in_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [SAMPLE_W-1:0]   o_out_sample,
    output logic                         o_keep,
    output logic                         o_frame_last
);

    localparam int DEPTH = 2 * MAX_FRAME;
    localparam int AW    = $clog2(DEPTH);
    localparam int POS_W = $clog2(MAX_FRAME);
    localparam int EW    = (AW + 1 > FRAME_LEN_W) ? AW + 1 : FRAME_LEN_W;

    logic [FRAME_LEN_W-1:0] r_frame_len;
    logic [THRESHOLD_W-1:0] r_threshold;
    logic [HANGOVER_W-1:0]  r_hangover;
    logic                   r_tx_enable;
    logic                   r_mute;

    logic [AW-1:0]          r_wp;
    logic                   r_full;
    logic [POS_W-1:0]       r_pos;
    logic                   r_speech;
    logic [GATE_W-1:0]      r_gate;
    logic [HANGOVER_W-1:0]  r_hang;
    logic [1:0]             r_flags;

    logic                   r_s1_valid;
    t_rd_tag                r_s1_tag;
    logic                   r_o_valid;
    logic [SAMPLE_W-1:0]    r_o_sample;
    logic                   r_o_keep;
    logic                   r_o_last;

    logic                   in_acc;
    logic                   s1_adv;
    logic [EW-1:0]          eff_len;
    logic [EW-1:0]          rd_sum;
    logic [AW-1:0]          rd_addr;
    logic                   rd_hit;
    logic                   frame_end;
    logic                   speech_now;
    logic                   run_gate;
    logic [SAMPLE_W-1:0]    ram_rdata;

    logic [AW-1:0]          n_wp;
    logic                   n_full;
    logic [POS_W-1:0]       n_pos;
    logic                   n_speech;
    logic [GATE_W-1:0]      n_gate;
    logic [HANGOVER_W-1:0]  n_hang;
    logic [1:0]             n_flags;
    logic [GATE_W-1:0]      g_st;
    logic [HANGOVER_W-1:0]  g_hang;
    logic                   g_pre;
    logic                   g_kept;

    assign s1_adv  = r_s1_valid && (!r_o_valid || i_ready);
    assign o_ready = !r_s1_valid || s1_adv;
    assign in_acc  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_len <= FRAME_LEN_RST;
            r_threshold <= '0;
            r_hangover  <= HANGOVER_RST;
            r_tx_enable <= 1'b0;
            r_mute      <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_FRAME_LEN: r_frame_len <= i_cfg_data[FRAME_LEN_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THRESHOLD_W-1:0];
                CFG_HANGOVER:  r_hangover  <= i_cfg_data[HANGOVER_W-1:0];
                CFG_TX_ENABLE: r_tx_enable <= i_cfg_data[0];
                CFG_MUTE:      r_mute      <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        eff_len = EW'(r_frame_len);
        if (eff_len == '0) begin
            eff_len = EW'(1);
        end else if (eff_len > EW'(MAX_FRAME)) begin
            eff_len = EW'(MAX_FRAME);
        end
        rd_sum = EW'(r_wp) + EW'(DEPTH) - (eff_len << 1);
        if (rd_sum >= EW'(DEPTH)) begin
            rd_sum = rd_sum - EW'(DEPTH);
        end
        rd_addr = rd_sum[AW-1:0];
        rd_hit  = r_full || (rd_addr < r_wp);
    end

    assign frame_end  = (EW'(r_pos) + EW'(1)) >= eff_len;
    assign speech_now = r_speech ||
        ($signed({i_in_sample[SAMPLE_W-1], i_in_sample}) >= $signed({1'b0, r_threshold}));
    assign run_gate   = r_tx_enable && !r_mute;

    always_comb begin
        g_st   = r_gate;
        g_hang = r_hang;
        g_pre  = 1'b0;
        g_kept = 1'b0;
        if (g_st != GATE_START && g_st != GATE_NORMAL) begin
            g_st = GATE_WAITING;
        end
        if (speech_now) begin
            if (g_st == GATE_WAITING) begin
                g_st = GATE_START;
            end
            g_hang = r_hangover;
        end
        if (g_st == GATE_START) begin
            g_pre = 1'b1;
            g_st  = GATE_NORMAL;
        end
        if (g_st == GATE_NORMAL) begin
            if (g_hang != '0) begin
                g_kept = 1'b1;
                g_hang = g_hang - HANGOVER_W'(1);
            end else begin
                g_st = GATE_WAITING;
            end
        end
    end

    always_comb begin
        n_wp     = (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + AW'(1);
        n_full   = r_full || (r_wp == AW'(DEPTH - 1));
        n_pos    = frame_end ? '0 : r_pos + POS_W'(1);
        n_speech = frame_end ? 1'b0 : speech_now;
        n_gate   = r_gate;
        n_hang   = r_hang;
        n_flags  = r_flags;
        if (frame_end) begin
            if (run_gate) begin
                n_gate  = g_st;
                n_hang  = g_hang;
                n_flags = {r_flags[0] | g_pre, g_kept};
            end else begin
                n_flags = {r_flags[0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp     <= '0;
            r_full   <= 1'b0;
            r_pos    <= '0;
            r_speech <= 1'b0;
            r_gate   <= GATE_WAITING;
            r_hang   <= '0;
            r_flags  <= '0;
        end else if (in_acc) begin
            r_wp     <= n_wp;
            r_full   <= n_full;
            r_pos    <= n_pos;
            r_speech <= n_speech;
            r_gate   <= n_gate;
            r_hang   <= n_hang;
            r_flags  <= n_flags;
        end
    end

    vghp_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_delay_ram (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (r_wp),
        .i_wdata (i_in_sample),
        .i_re    (in_acc),
        .i_raddr (rd_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_o_valid <= 1'b1;
            end else if (i_ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_tag <= '{keep: r_flags[1], last: frame_end, hit: rd_hit};
        end
        if (s1_adv) begin
            r_o_sample <= r_s1_tag.hit ? ram_rdata : '0;
            r_o_keep   <= r_s1_tag.keep;
            r_o_last   <= r_s1_tag.last;
        end
    end

    assign o_valid      = r_o_valid;
    assign o_out_sample = r_o_sample;
    assign o_keep       = r_o_keep;
    assign o_frame_last = r_o_last;

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && frame_end |=> r_pos == '0 && !r_speech)
        else $error("frame position not restarted after frame end");

    a_gate_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && !run_gate |=> $stable(r_gate) && $stable(r_hang))
        else $error("gate state moved while transmit disabled or muted");

    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !s1_adv |=> r_s1_valid && $stable(r_s1_tag))
        else $error("read stage dropped or changed while stalled");

    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("fill flag cleared outside reset");

endmodule
